// ===== rtl/bgm_pkg.sv =====
// Package for the button gesture mode controller.
// Holds widths, register indexes, gesture codes, FSM state type and status struct.
// No dependencies.
package bgm_pkg;

   // Press/gap timer width; the timer saturates at its all-ones value
   localparam int COUNT_WIDTH = 16;
   // Width of each configuration register
   localparam int CFG_WIDTH = 16;
   // Compare width that holds both the timer and a threshold
   localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

   // Configuration port
   localparam int CSR_IDX_WIDTH = 2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LONG_PRESS = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DOUBLE_GAP = 2'd1;

   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] DOUBLE_GAP_RESET = 16'd300;

   // Color mode cycles 0 .. MODE_LAST
   localparam logic [1:0] MODE_LAST = 2'd2;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SHORT  = 2'd1,
      EV_LONG   = 2'd2,
      EV_DOUBLE = 2'd3
   } gesture_type;

   typedef enum logic [1:0] {
      ST_IDLE              = 2'd0,
      ST_HELD              = 2'd1,
      ST_GAP               = 2'd2,
      ST_HOLD_AFTER_DOUBLE = 2'd3
   } state_type;

   // Driver status after one tick
   typedef struct packed {
      logic [1:0] led_mode;
      logic       led_enabled;
      logic       pwm_mode_applied;
      logic       pwm_update;
      logic       strip_update;
   } status_type;

endpackage

// ===== rtl/bgm_req_if.sv =====
// Input channel: one word per tick carrying the sampled button level.
// Standalone interface, no dependencies.
interface bgm_req_if;
   logic valid;
   logic ready;
   logic button_level;

   modport source (output valid, output button_level, input ready);
   modport sink   (input valid, input button_level, output ready);
endinterface

// ===== rtl/bgm_rsp_if.sv =====
// Result channel: one word per tick with gesture event and driver status.
// Standalone interface, no dependencies.
interface bgm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] gesture_event;
   logic [1:0] led_mode;
   logic       led_enabled;
   logic       pwm_mode_applied;
   logic       pwm_update;
   logic       strip_update;

   modport source (output valid, output gesture_event, output led_mode,
                   output led_enabled, output pwm_mode_applied,
                   output pwm_update, output strip_update, input ready);
   modport sink   (input valid, input gesture_event, input led_mode,
                   input led_enabled, input pwm_mode_applied,
                   input pwm_update, input strip_update, output ready);
endinterface

// ===== rtl/button_gesture_mode_controller.sv =====
// Button gesture mode controller: short, long and double press detection.
// The rsp word of an accepted req word is loaded into the output register in the cycle after it.
// Throughput: one word per cycle; req is taken while a result waits if rsp takes it too.
// Reset (synchronous, active high): idle, timer 0, mode 0, PWM/LED flags 1,
// thresholds 1000 and 300 ticks. Depends on bgm_pkg, bgm_req_if, bgm_rsp_if,
// bgm_gesture_fsm and bgm_mode_regs.
module button_gesture_mode_controller (
   input  logic                              clock,
   input  logic                              reset,
   bgm_req_if.sink                           req_chan,
   bgm_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [bgm_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [bgm_pkg::CFG_WIDTH-1:0]     csr_wdata
);
   import bgm_pkg::*;

   logic [CFG_WIDTH-1:0] long_press_ff;
   logic [CFG_WIDTH-1:0] double_gap_ff;
   logic                 accept;
   gesture_type          gesture_event;
   status_type           status;

   logic                 rsp_valid_ff;
   gesture_type          event_ff;
   status_type           status_ff;

   // Take a word whenever the output register is empty or drains this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LONG_PRESS_RESET;
         double_gap_ff <= DOUBLE_GAP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LONG_PRESS: long_press_ff <= csr_wdata;
            CSR_DOUBLE_GAP: double_gap_ff <= csr_wdata;
            default: begin
               long_press_ff <= long_press_ff;
            end
         endcase
      end
   end

   bgm_gesture_fsm u_fsm (
      .clock            (clock),
      .reset            (reset),
      .advance          (accept),
      .button_level     (req_chan.button_level),
      .long_press_ticks (long_press_ff),
      .double_gap_ticks (double_gap_ff),
      .gesture_event    (gesture_event)
   );

   bgm_mode_regs u_mode (
      .clock         (clock),
      .reset         (reset),
      .advance       (accept),
      .gesture_event (gesture_event),
      .status        (status)
   );

   // Output register: load on accept, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff  <= gesture_event;
         status_ff <= status;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.gesture_event    = event_ff;
   assign rsp_chan.led_mode         = status_ff.led_mode;
   assign rsp_chan.led_enabled      = status_ff.led_enabled;
   assign rsp_chan.pwm_mode_applied = status_ff.pwm_mode_applied;
   assign rsp_chan.pwm_update       = status_ff.pwm_update;
   assign rsp_chan.strip_update     = status_ff.strip_update;

endmodule

// ===== rtl/bgm_gesture_fsm.sv =====
// Gesture detector: times presses and gaps and decides the event of each tick.
// Depends on bgm_pkg.
module bgm_gesture_fsm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          button_level,
   input  logic [bgm_pkg::CFG_WIDTH-1:0] long_press_ticks,
   input  logic [bgm_pkg::CFG_WIDTH-1:0] double_gap_ticks,
   output bgm_pkg::gesture_type          gesture_event
);
   import bgm_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic [CMP_WIDTH-1:0]   count_cmp, long_cmp, gap_cmp;
   logic                   below_long, below_gap, above_gap;

   // Saturating timer step and threshold compares
   assign count_inc  = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_WIDTH'(1);
   assign count_cmp  = CMP_WIDTH'(count_inc);
   assign long_cmp   = CMP_WIDTH'(long_press_ticks);
   assign gap_cmp    = CMP_WIDTH'(double_gap_ticks);
   assign below_long = count_cmp < long_cmp;
   assign below_gap  = count_cmp < gap_cmp;
   assign above_gap  = count_cmp > gap_cmp;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_HELD: begin
            if (!button_level) begin
               state_in = below_long ? ST_GAP : ST_IDLE;
            end
         end
         ST_GAP: begin
            if (below_gap && button_level) begin
               state_in = ST_HOLD_AFTER_DOUBLE;
            end else if (above_gap) begin
               state_in = ST_IDLE;
            end
         end
         ST_HOLD_AFTER_DOUBLE: begin
            if (!button_level) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = button_level ? ST_HELD : ST_IDLE;
         end
      endcase
   end

   // Event and timer update
   always_comb begin
      gesture_event = EV_NONE;
      count_in      = count_ff;
      case (state_ff)
         ST_HELD: begin
            count_in = count_inc;
            if (!button_level) begin
               if (below_long) begin
                  count_in = '0;
               end else begin
                  gesture_event = EV_LONG;
               end
            end
         end
         ST_GAP: begin
            count_in = count_inc;
            if (below_gap && button_level) begin
               gesture_event = EV_DOUBLE;
            end else if (above_gap) begin
               gesture_event = EV_SHORT;
            end
         end
         ST_HOLD_AFTER_DOUBLE: begin
            count_in = count_ff;
         end
         default: begin
            if (button_level) begin
               count_in = '0;
            end
         end
      endcase
   end

   // Advance once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/bgm_mode_regs.sv =====
// Mode and flag registers driven by gesture events; reports post-tick status.
// Depends on bgm_pkg.
module bgm_mode_regs (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  bgm_pkg::gesture_type gesture_event,
   output bgm_pkg::status_type  status
);
   import bgm_pkg::*;

   logic [1:0] mode_ff, mode_in;
   logic       pwm_mode_ff, pwm_mode_in;
   logic       led_on_ff, led_on_in;
   logic       pwm_applied_ff, pwm_applied_in;
   logic       pwm_upd, strip_upd;

   // Apply the event of this tick
   always_comb begin
      mode_in        = mode_ff;
      pwm_mode_in    = pwm_mode_ff;
      led_on_in      = led_on_ff;
      pwm_applied_in = pwm_applied_ff;
      pwm_upd        = 1'b0;
      strip_upd      = 1'b0;
      case (gesture_event)
         EV_SHORT: begin
            mode_in   = (mode_ff >= MODE_LAST) ? 2'd0 : mode_ff + 2'd1;
            strip_upd = 1'b1;
         end
         EV_LONG: begin
            pwm_applied_in = pwm_mode_ff;
            pwm_mode_in    = ~pwm_mode_ff;
            pwm_upd        = 1'b1;
         end
         EV_DOUBLE: begin
            led_on_in      = ~led_on_ff;
            pwm_applied_in = pwm_mode_ff;
            pwm_upd        = 1'b1;
            strip_upd      = 1'b1;
         end
         default: begin
            pwm_upd = 1'b0;
         end
      endcase
   end

   assign status.led_mode         = mode_in;
   assign status.led_enabled      = led_on_in;
   assign status.pwm_mode_applied = pwm_applied_in;
   assign status.pwm_update       = pwm_upd;
   assign status.strip_update     = strip_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 2'd0;
         pwm_mode_ff    <= 1'b1;
         led_on_ff      <= 1'b1;
         pwm_applied_ff <= 1'b1;
      end else if (advance) begin
         mode_ff        <= mode_in;
         pwm_mode_ff    <= pwm_mode_in;
         led_on_ff      <= led_on_in;
         pwm_applied_ff <= pwm_applied_in;
      end
   end

endmodule

// ===== bench/tb_button_gesture_mode_controller.sv =====
// Testbench for button_gesture_mode_controller: drives tick words, predicts every result
// word with a gesture tracker and checks each field. Depends on bgm_pkg, bgm_req_if,
// bgm_rsp_if and the RTL top level.
`timescale 1ns / 100ps

module tb_button_gesture_mode_controller;
   import bgm_pkg::*;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_3 = 2'd3;
   localparam int LONG_HOLD_OFF = 80;

   typedef struct packed {
      gesture_type gesture;
      status_type  status;
   } tick_result_type;

   // Gesture tracker: own copy of thresholds and state, queue of expected words
   class gesture_tracker_type;
      logic [CFG_WIDTH-1:0]   long_ticks;
      logic [CFG_WIDTH-1:0]   gap_ticks;
      state_type              state;
      logic [COUNT_WIDTH-1:0] elapsed;
      logic [1:0]             mode;
      logic                   pwm_flag;
      logic                   led_on;
      logic                   pwm_applied;
      tick_result_type        expected_words[$];
      int                     errors;

      function new();
         long_ticks  = LONG_PRESS_RESET;
         gap_ticks   = DOUBLE_GAP_RESET;
         state       = ST_IDLE;
         elapsed     = '0;
         mode        = 2'd0;
         pwm_flag    = 1'b1;
         led_on      = 1'b1;
         pwm_applied = 1'b1;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_WIDTH-1:0] index, logic [CFG_WIDTH-1:0] value);
         if (index == CSR_LONG_PRESS) begin
            long_ticks = value;
         end else if (index == CSR_DOUBLE_GAP) begin
            gap_ticks = value;
         end
      endfunction

      // Advance the gesture state by one tick and queue the word it yields
      function void note_tick(logic level);
         gesture_type     ev;
         tick_result_type word;
         ev = EV_NONE;
         case (state)
            ST_HELD: begin
               if (elapsed != '1) elapsed = elapsed + COUNT_WIDTH'(1);
               if (!level) begin
                  if (elapsed < long_ticks) begin
                     elapsed = '0;
                     state = ST_GAP;
                  end else begin
                     ev = EV_LONG;
                     state = ST_IDLE;
                  end
               end
            end
            ST_GAP: begin
               if (elapsed != '1) elapsed = elapsed + COUNT_WIDTH'(1);
               if (elapsed < gap_ticks && level) begin
                  ev = EV_DOUBLE;
                  state = ST_HOLD_AFTER_DOUBLE;
               end else if (elapsed > gap_ticks) begin
                  ev = EV_SHORT;
                  state = ST_IDLE;
               end
            end
            ST_HOLD_AFTER_DOUBLE: begin
               if (!level) state = ST_IDLE;
            end
            default: begin
               state = ST_IDLE;
               if (level) begin
                  elapsed = '0;
                  state = ST_HELD;
               end
            end
         endcase

         word.status.pwm_update   = 1'b0;
         word.status.strip_update = 1'b0;
         if (ev == EV_SHORT) begin
            mode = (mode >= MODE_LAST) ? 2'd0 : mode + 2'd1;
            word.status.strip_update = 1'b1;
         end else if (ev == EV_LONG) begin
            pwm_applied = pwm_flag;
            pwm_flag = ~pwm_flag;
            word.status.pwm_update = 1'b1;
         end else if (ev == EV_DOUBLE) begin
            led_on = ~led_on;
            pwm_applied = pwm_flag;
            word.status.pwm_update   = 1'b1;
            word.status.strip_update = 1'b1;
         end
         word.gesture                 = ev;
         word.status.led_mode         = mode;
         word.status.led_enabled      = led_on;
         word.status.pwm_mode_applied = pwm_applied;
         expected_words.push_back(word);
      endfunction

      function void compare_field(string name, logic [1:0] want, logic [1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      // Match one result word against the oldest expectation
      function void check_word(logic [1:0] gesture, status_type status);
         tick_result_type want;
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t ns: result word expected none, got event %0d status %h",
                     $time, gesture, status);
            return;
         end
         want = expected_words.pop_front();
         compare_field("gesture_event", want.gesture, gesture);
         compare_field("led_mode", want.status.led_mode, status.led_mode);
         compare_field("led_enabled", 2'(want.status.led_enabled),
                       2'(status.led_enabled));
         compare_field("pwm_mode_applied", 2'(want.status.pwm_mode_applied),
                       2'(status.pwm_mode_applied));
         compare_field("pwm_update", 2'(want.status.pwm_update), 2'(status.pwm_update));
         compare_field("strip_update", 2'(want.status.strip_update),
                       2'(status.strip_update));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [CFG_WIDTH-1:0]     csr_wdata;

   bgm_req_if req_if();
   bgm_rsp_if rsp_if();

   gesture_tracker_type tracker;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int holds_asked   = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int ticks_sent    = 0;

   button_gesture_mode_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off whenever one is asked for
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_if.ready <= 1'b0;
         hold_left <= LONG_HOLD_OFF;
         holds_served <= holds_served + 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Check result words first, then predict from tick words taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            tracker.check_word(rsp_if.gesture_event,
                               status_type'({rsp_if.led_mode, rsp_if.led_enabled,
                                             rsp_if.pwm_mode_applied, rsp_if.pwm_update,
                                             rsp_if.strip_update}));
         end
         if (req_if.valid && req_if.ready) begin
            tracker.note_tick(req_if.button_level);
         end
      end
   end

   // Offer one tick word, with random idle cycles ahead of it
   task automatic send_tick(input logic level);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.button_level <= level;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic drive_level(input logic level, input int count);
      repeat (count) send_tick(level);
   endtask

   // Write one register, then leave the port idle
   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] index,
                            input logic [CFG_WIDTH-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.write_reg(index, value);
      @(posedge clock);
   endtask

   // Drop valid and wait until every expected word has come back
   task automatic drain;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_words.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Pick a length at or just around a threshold, or at random from 1 to 2*thr+2
   function automatic int near_threshold(input int thr);
      int len;
      case ($urandom_range(3))
         0: len = thr - 1;
         1: len = thr;
         2: len = thr + 1;
         default: len = $urandom_range(2 * thr + 2, 1);
      endcase
      return (len < 1) ? 1 : len;
   endfunction

   // Mostly press / release / second press sequences, some level noise
   task automatic random_gestures(input int count);
      int start;
      int long_thr;
      int gap_thr;
      start = ticks_sent;
      long_thr = int'(tracker.long_ticks);
      gap_thr = int'(tracker.gap_ticks);
      while (ticks_sent - start < count) begin
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(8, 1)) send_tick(1'($urandom_range(1)));
         end else begin
            drive_level(1'b1, near_threshold(long_thr));
            drive_level(1'b0, near_threshold(gap_thr));
            if ($urandom_range(1)) begin
               drive_level(1'b1, near_threshold(long_thr));
               drive_level(1'b0, $urandom_range(gap_thr + 2, 1));
            end
         end
      end
   endtask

   task automatic run_phase(input int long_thr, input int gap_thr, input int idle_pct,
                            input int stall_pct, input bit hold_off, input int count);
      write_reg(CSR_LONG_PRESS, CFG_WIDTH'(long_thr));
      write_reg(CSR_DOUBLE_GAP, CFG_WIDTH'(gap_thr));
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (hold_off) holds_asked++;
      random_gestures(count);
      drain();
   endtask

   initial begin
      tracker = new();
      req_if.valid = 1'b0;
      req_if.button_level = 1'b0;
      rsp_if.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_LONG_PRESS;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset thresholds: a short press, then a quick double press
      drive_level(1'b1, 3);
      drive_level(1'b0, 302);
      drive_level(1'b1, 2);
      drive_level(1'b0, 5);
      drive_level(1'b1, 2);
      drive_level(1'b0, 2);
      drain();

      // Directed: short, double, gap equal to threshold while held, long
      write_reg(CSR_LONG_PRESS, 16'd3);
      write_reg(CSR_DOUBLE_GAP, 16'd2);
      drive_level(1'b1, 1);
      drive_level(1'b0, 4);
      drive_level(1'b1, 1);
      drive_level(1'b0, 1);
      drive_level(1'b1, 3);
      drive_level(1'b0, 1);
      drive_level(1'b1, 1);
      drive_level(1'b0, 2);
      drive_level(1'b1, 5);
      drive_level(1'b0, 2);
      drain();

      // Unused register indexes must leave the thresholds alone
      write_reg(CSR_SPARE_2, CFG_WIDTH'($urandom_range(65535)));
      write_reg(CSR_SPARE_3, CFG_WIDTH'($urandom_range(65535)));

      run_phase(4, 3, 0, 0, 1'b0, 200);
      run_phase(5, 0, 48, 0, 1'b0, 200);
      run_phase(0, 7, 0, 48, 1'b0, 200);
      run_phase(1, 1, 33, 33, 1'b0, 200);
      run_phase(6, 4, 0, 33, 1'b1, 200);
      run_phase(2, 5, 0, 0, 1'b0, 200);

      // Widest gap threshold: quick double presses only
      write_reg(CSR_LONG_PRESS, 16'd2);
      write_reg(CSR_DOUBLE_GAP, 16'hFFFF);
      send_idle_pct = 33;
      rsp_stall_pct = 33;
      repeat (3) begin
         drive_level(1'b1, 1);
         drive_level(1'b0, $urandom_range(4, 1));
         drive_level(1'b1, 2);
         drive_level(1'b0, 1);
      end
      drain();

      // Widest long threshold: a held press stays well short of it
      write_reg(CSR_LONG_PRESS, 16'hFFFF);
      write_reg(CSR_DOUBLE_GAP, 16'd1);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      drive_level(1'b1, 40);
      drive_level(1'b0, 3);
      drain();

      repeat (4) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("timeout: result words still outstanding");
      $display("== FAIL ==");
      $finish;
   end

endmodule
